@@ sv/nrtp_pkg.sv @@
// ============================================================================
// nrtp_pkg : shared types and constants of the nested region time profiler
// Sizes, event and status codes, and the per-region record layout.
// ============================================================================
`default_nettype none

package nrtp_pkg;

  localparam int REGIONS        = 64;
  localparam int REGION_BITS    = $clog2(REGIONS);
  localparam int STACK_DEPTH    = 128;
  localparam int STACK_ADDR_BITS = $clog2(STACK_DEPTH);
  localparam int SP_BITS        = $clog2(STACK_DEPTH + 1);
  localparam int TIME_BITS      = 48;
  localparam int CALL_BITS      = 32;
  localparam int ACTION_BITS    = 2;
  localparam int STATUS_BITS    = 3;
  localparam int REGION_IN_BITS = 6;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_START     = 2'd0,
    ACT_STOP_EXCL = 2'd1,
    ACT_STOP_INCL = 2'd2,
    ACT_READ      = 2'd3
  } action_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK        = 3'd0,
    STAT_RESTART   = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_MISMATCH  = 3'd3,
    STAT_IDLE_STOP = 3'd4
  } status_t;

  // One entry of the region memory
  typedef struct packed {
    logic                 running;
    logic [CALL_BITS-1:0] calls;
    logic [TIME_BITS-1:0] wall_start;
    logic [TIME_BITS-1:0] wall_snap;
    logic [TIME_BITS-1:0] wall_acc;
    logic [TIME_BITS-1:0] cpu_start;
    logic [TIME_BITS-1:0] cpu_snap;
    logic [TIME_BITS-1:0] cpu_acc;
  } region_rec_t;

  // Stack commands from the sequencer
  typedef struct packed {
    logic                   rd_top;
    logic                   push;
    logic                   pop;
    logic [REGION_BITS-1:0] region;
  } stack_cmd_t;

endpackage

`default_nettype wire

@@ sv/nrtp_if.sv @@
// ============================================================================
// nrtp_if : event and result channels of the nested region time profiler
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ============================================================================
`default_nettype none

interface nrtp_evt_if;
  logic                                  valid;
  logic                                  ready;
  logic [nrtp_pkg::ACTION_BITS-1:0]      action;
  logic [nrtp_pkg::REGION_IN_BITS-1:0]   region;
  logic [nrtp_pkg::TIME_BITS-1:0]        wall_now;
  logic [nrtp_pkg::TIME_BITS-1:0]        cpu_now;

  modport source (output valid, action, region, wall_now, cpu_now, input ready);
  modport sink   (input valid, action, region, wall_now, cpu_now, output ready);
endinterface

interface nrtp_res_if;
  logic                              valid;
  logic                              ready;
  logic [nrtp_pkg::STATUS_BITS-1:0]  status;
  logic [nrtp_pkg::TIME_BITS-1:0]    wall_total;
  logic [nrtp_pkg::TIME_BITS-1:0]    cpu_total;
  logic [nrtp_pkg::CALL_BITS-1:0]    calls;

  modport source (output valid, status, wall_total, cpu_total, calls, input ready);
  modport sink   (input valid, status, wall_total, cpu_total, calls, output ready);
endinterface

`default_nettype wire

@@ sv/nrtp_region_store.sv @@
// ============================================================================
// nrtp_region_store : per-region record memory
// Synchronous memory with one write and one registered read port; a valid
// flag per entry makes unwritten entries read as all zero after reset.
// ============================================================================
`default_nettype none

module nrtp_region_store (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              rd_en,
  input  wire logic [nrtp_pkg::REGION_BITS-1:0]  rd_addr,
  output nrtp_pkg::region_rec_t                  rd_data,
  input  wire logic                              wr_en,
  input  wire logic [nrtp_pkg::REGION_BITS-1:0]  wr_addr,
  input  wire nrtp_pkg::region_rec_t             wr_data
);

  nrtp_pkg::region_rec_t                mem [nrtp_pkg::REGIONS];
  nrtp_pkg::region_rec_t                rd_q;
  logic                                 rd_valid;
  logic [nrtp_pkg::REGIONS-1:0]         entry_valid;

  // Write and registered read of the record array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Track written entries; reset marks every region as cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= entry_valid[rd_addr];
      end
    end
  end

  // Unwritten entries read as zero
  assign rd_data = rd_valid ? rd_q : '0;

endmodule

`default_nettype wire

@@ sv/nrtp_region_stack.sv @@
// ============================================================================
// nrtp_region_stack : stack of open region ids
// Stack memory with a pointer register; the top entry is read into a
// register on request, push and pop move the pointer by one.
// ============================================================================
`default_nettype none

module nrtp_region_stack (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire nrtp_pkg::stack_cmd_t              cmd,
  output logic [nrtp_pkg::SP_BITS-1:0]           sp,
  output logic [nrtp_pkg::REGION_BITS-1:0]       top
);

  logic [nrtp_pkg::REGION_BITS-1:0] mem [nrtp_pkg::STACK_DEPTH];
  logic [nrtp_pkg::SP_BITS-1:0]     sp_m1;

  assign sp_m1 = sp - nrtp_pkg::SP_BITS'(1);

  // Push writes at the pointer; top read addresses one below it
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[sp[nrtp_pkg::STACK_ADDR_BITS-1:0]] <= cmd.region;
    end
    if (cmd.rd_top) begin
      top <= mem[sp_m1[nrtp_pkg::STACK_ADDR_BITS-1:0]];
    end
  end

  // Advance or drop the pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.push) begin
      sp <= sp + nrtp_pkg::SP_BITS'(1);
    end else if (cmd.pop) begin
      sp <= sp_m1;
    end
  end

`ifndef SYNTH
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= nrtp_pkg::SP_BITS'(nrtp_pkg::STACK_DEPTH))
    else $error("stack pointer beyond depth");
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (sp != nrtp_pkg::SP_BITS'(nrtp_pkg::STACK_DEPTH)) && !cmd.pop)
    else $error("push into a full stack");
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (sp != '0))
    else $error("pop from an empty stack");
`endif

endmodule

`default_nettype wire

@@ sv/nested_region_time_profiler.sv @@
// ============================================================================
// nested_region_time_profiler : wall and cpu time profiler for nested regions
// Sequencer and arithmetic around the region memory and the region stack.
// ============================================================================
// Usage:
//   evt carries one event (start, exclusive stop, inclusive stop, read) for
//   one region with the current wall and cpu timestamps. res returns one
//   result per event: status and the region's totals after the event.
//   An event is taken only when the block is idle. It then runs through
//   these steps: the transfer edge reads the region memory and the stack
//   top, the difference state registers the elapsed and nested-time
//   differences and the status, and the write-back state writes the record
//   back and loads the result register, which raises res.valid. The next
//   event can be taken in the cycle after the result is loaded, not while
//   an earlier one is still in the read-modify-write of the region
//   memory. The result register lets the next event run while a result
//   waits; if res is still stalled at write-back time, the block holds there.
//   Reset clears the stack pointer, global totals and per-region valid flags
//   at once, so all regions read as idle with zero totals; no clearing pass.
//   Errors return a nonzero status and leave all state unchanged.
// ============================================================================
`default_nettype none

module nested_region_time_profiler (
  input wire logic        clk,
  input wire logic        rst,
  nrtp_evt_if.sink        evt,
  nrtp_res_if.source      res
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIFF = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t                                state, state_next;
  nrtp_pkg::action_t                     act_q;
  logic [nrtp_pkg::REGION_BITS-1:0]      reg_q;
  logic [nrtp_pkg::TIME_BITS-1:0]        wnow_q, cnow_q;
  logic [nrtp_pkg::TIME_BITS-1:0]        wdt_q, wadv_q, cdt_q, cadv_q;
  nrtp_pkg::status_t                     status_q, status_next;
  logic [nrtp_pkg::TIME_BITS-1:0]        gwall, gcpu;

  nrtp_pkg::region_rec_t                 rec, rec_new;
  logic                                  rec_wr;
  nrtp_pkg::stack_cmd_t                  stk_cmd;
  logic [nrtp_pkg::SP_BITS-1:0]          sp;
  logic [nrtp_pkg::REGION_BITS-1:0]      top;

  logic                                  accept, upd_fire, ok_update, is_stop, is_excl;
  logic [nrtp_pkg::TIME_BITS-1:0]        wsub, csub;

  assign evt.ready = (state == ST_IDLE);
  assign accept    = evt.valid && evt.ready;
  assign upd_fire  = (state == ST_UPD) && (!res.valid || res.ready);
  assign is_stop   = (act_q == nrtp_pkg::ACT_STOP_EXCL) || (act_q == nrtp_pkg::ACT_STOP_INCL);
  assign is_excl   = (act_q == nrtp_pkg::ACT_STOP_EXCL);
  assign ok_update = (status_q == nrtp_pkg::STAT_OK) &&
                     ((act_q == nrtp_pkg::ACT_START) || is_stop);
  assign rec_wr    = upd_fire && ok_update;

  nrtp_region_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (evt.region[nrtp_pkg::REGION_BITS-1:0]),
    .rd_data (rec),
    .wr_en   (rec_wr),
    .wr_addr (reg_q),
    .wr_data (rec_new)
  );

  // Stack commands: read the top on transfer, push or pop on write-back
  always_comb begin
    stk_cmd.rd_top = accept;
    stk_cmd.push   = rec_wr && (act_q == nrtp_pkg::ACT_START);
    stk_cmd.pop    = rec_wr && is_stop;
    stk_cmd.region = reg_q;
  end

  nrtp_region_stack u_stack (
    .clk (clk),
    .rst (rst),
    .cmd (stk_cmd),
    .sp  (sp),
    .top (top)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept)   state_next = ST_DIFF;
      ST_DIFF:               state_next = ST_UPD;
      ST_UPD:  if (upd_fire) state_next = ST_IDLE;
      default:               state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the event fields
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q  <= nrtp_pkg::action_t'(evt.action);
      reg_q  <= evt.region[nrtp_pkg::REGION_BITS-1:0];
      wnow_q <= evt.wall_now;
      cnow_q <= evt.cpu_now;
    end
  end

  // Check the event against the region flag and the stack top
  always_comb begin
    status_next = nrtp_pkg::STAT_OK;
    case (act_q)
      nrtp_pkg::ACT_START: begin
        if (rec.running) begin
          status_next = nrtp_pkg::STAT_RESTART;
        end else if (sp == nrtp_pkg::SP_BITS'(nrtp_pkg::STACK_DEPTH)) begin
          status_next = nrtp_pkg::STAT_FULL;
        end
      end
      nrtp_pkg::ACT_STOP_EXCL, nrtp_pkg::ACT_STOP_INCL: begin
        if ((sp == '0) || (top != reg_q)) begin
          status_next = nrtp_pkg::STAT_MISMATCH;
        end else if (!rec.running) begin
          status_next = nrtp_pkg::STAT_IDLE_STOP;
        end
      end
      default: status_next = nrtp_pkg::STAT_OK;
    endcase
  end

  // Register elapsed time and nested advance since the start
  always_ff @(posedge clk) begin
    if (state == ST_DIFF) begin
      wdt_q    <= wnow_q - rec.wall_start;
      cdt_q    <= cnow_q - rec.cpu_start;
      wadv_q   <= gwall - rec.wall_snap;
      cadv_q   <= gcpu - rec.cpu_snap;
      status_q <= status_next;
    end
  end

  // Build the updated record
  assign wsub = is_excl ? wadv_q : '0;
  assign csub = is_excl ? cadv_q : '0;

  always_comb begin
    rec_new = rec;
    if (act_q == nrtp_pkg::ACT_START) begin
      rec_new.running    = 1'b1;
      rec_new.wall_start = wnow_q;
      rec_new.cpu_start  = cnow_q;
      rec_new.wall_snap  = gwall;
      rec_new.cpu_snap   = gcpu;
    end else begin
      rec_new.running  = 1'b0;
      rec_new.wall_acc = rec.wall_acc + wdt_q - wsub;
      rec_new.cpu_acc  = rec.cpu_acc + cdt_q - csub;
      rec_new.calls    = (rec.calls == '1) ? rec.calls
                                           : rec.calls + nrtp_pkg::CALL_BITS'(1);
    end
  end

  // Advance global totals on an exclusive stop
  always_ff @(posedge clk) begin
    if (rst) begin
      gwall <= '0;
      gcpu  <= '0;
    end else if (rec_wr && is_excl) begin
      gwall <= gwall + wdt_q - wadv_q;
      gcpu  <= gcpu + cdt_q - cadv_q;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (upd_fire) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      res.status     <= status_q;
      res.wall_total <= ok_update ? rec_new.wall_acc : rec.wall_acc;
      res.cpu_total  <= ok_update ? rec_new.cpu_acc : rec.cpu_acc;
      res.calls      <= ok_update ? rec_new.calls : rec.calls;
    end
  end

`ifndef SYNTH
  a_accept_to_diff: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_DIFF))
    else $error("transfer not followed by difference stage");
  a_write_in_upd: assert property (@(posedge clk) disable iff (rst)
    rec_wr |-> (state == ST_UPD) && (status_q == nrtp_pkg::STAT_OK))
    else $error("record written outside write-back or on error");
  a_global_hold: assert property (@(posedge clk) disable iff (rst)
    !upd_fire |=> $stable(gwall) && $stable(gcpu))
    else $error("global totals changed without a write-back");
  a_error_keeps_sp: assert property (@(posedge clk) disable iff (rst)
    (upd_fire && (status_q != nrtp_pkg::STAT_OK)) |=> $stable(sp))
    else $error("error event moved the stack pointer");
`endif

endmodule

`default_nettype wire

@@ dv/nested_region_time_profiler_test.sv @@
`timescale 1ns / 100ps
// ============================================================================
// nested_region_time_profiler_test : self-checking bench of the region profiler
// Drives start, stop and read events over the valid/ready event channel and
// compares every result transfer with an in-bench prediction of the region
// records, the region stack and the nested-time totals. A directed table comes
// first, then random nested start/stop sequences with some malformed events,
// with deep dives that open every region at once.
// ============================================================================

module nested_region_time_profiler_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [nrtp_pkg::TIME_BITS-1:0] TMAX = {nrtp_pkg::TIME_BITS{1'b1}};

  typedef struct packed {
    nrtp_pkg::status_t              status;
    logic [nrtp_pkg::TIME_BITS-1:0] wall_total;
    logic [nrtp_pkg::TIME_BITS-1:0] cpu_total;
    logic [nrtp_pkg::CALL_BITS-1:0] calls;
  } totals_t;

  typedef struct {
    nrtp_pkg::action_t                   action;
    logic [nrtp_pkg::REGION_IN_BITS-1:0] region;
    logic [nrtp_pkg::TIME_BITS-1:0]      wall;
    logic [nrtp_pkg::TIME_BITS-1:0]      cpu;
    bit                                  fixed;
    totals_t                             totals;
  } stim_row_t;

  logic clk;
  logic rst;

  nrtp_evt_if evt ();
  nrtp_res_if res ();

  nested_region_time_profiler i_dut (
    .clk (clk),
    .rst (rst),
    .evt (evt.sink),
    .res (res.source)
  );

  // Predicted region records, open-region stack and nested-time totals
  logic [nrtp_pkg::TIME_BITS-1:0]   reg_wall_start [nrtp_pkg::REGIONS];
  logic [nrtp_pkg::TIME_BITS-1:0]   reg_wall_snap  [nrtp_pkg::REGIONS];
  logic [nrtp_pkg::TIME_BITS-1:0]   reg_wall_acc   [nrtp_pkg::REGIONS];
  logic [nrtp_pkg::TIME_BITS-1:0]   reg_cpu_start  [nrtp_pkg::REGIONS];
  logic [nrtp_pkg::TIME_BITS-1:0]   reg_cpu_snap   [nrtp_pkg::REGIONS];
  logic [nrtp_pkg::TIME_BITS-1:0]   reg_cpu_acc    [nrtp_pkg::REGIONS];
  logic [nrtp_pkg::CALL_BITS-1:0]   reg_calls      [nrtp_pkg::REGIONS];
  logic                             reg_running    [nrtp_pkg::REGIONS];
  logic [nrtp_pkg::REGION_BITS-1:0] open_stack     [nrtp_pkg::STACK_DEPTH];
  int                               open_depth;
  logic [nrtp_pkg::TIME_BITS-1:0]   nest_wall;
  logic [nrtp_pkg::TIME_BITS-1:0]   nest_cpu;

  totals_t   expected_totals [$];
  stim_row_t directed_rows [$];

  bit      row_fixed;
  totals_t row_fixed_totals;
  int      tx_idle_pct;
  int      rx_idle_pct;
  int      error_count;
  int      cycle_count;
  logic [nrtp_pkg::TIME_BITS-1:0] wall_clk;
  logic [nrtp_pkg::TIME_BITS-1:0] cpu_clk;

  // Stamp value from a small constant
  function automatic logic [nrtp_pkg::TIME_BITS-1:0] ts(int unsigned v);
    return nrtp_pkg::TIME_BITS'(v);
  endfunction

  // Top entry of the predicted stack
  function automatic logic [nrtp_pkg::REGION_BITS-1:0] stack_top();
    return open_stack[nrtp_pkg::STACK_ADDR_BITS'(open_depth - 1)];
  endfunction

  // Apply one event to the predicted state and return the region's totals
  function automatic totals_t profile_event(nrtp_pkg::action_t act,
                                            logic [nrtp_pkg::REGION_IN_BITS-1:0] rgn_in,
                                            logic [nrtp_pkg::TIME_BITS-1:0] wall_now,
                                            logic [nrtp_pkg::TIME_BITS-1:0] cpu_now);
    logic [nrtp_pkg::REGION_BITS-1:0] r;
    nrtp_pkg::status_t                st;
    logic [nrtp_pkg::TIME_BITS-1:0]   wall_del;
    logic [nrtp_pkg::TIME_BITS-1:0]   cpu_del;
    totals_t                          t;
    r  = nrtp_pkg::REGION_BITS'(rgn_in % nrtp_pkg::REGIONS);
    st = nrtp_pkg::STAT_OK;
    case (act)
      nrtp_pkg::ACT_START: begin
        if (reg_running[r]) begin
          st = nrtp_pkg::STAT_RESTART;
        end else if (open_depth >= nrtp_pkg::STACK_DEPTH) begin
          st = nrtp_pkg::STAT_FULL;
        end else begin
          reg_wall_start[r] = wall_now;
          reg_wall_snap[r]  = nest_wall;
          reg_cpu_start[r]  = cpu_now;
          reg_cpu_snap[r]   = nest_cpu;
          reg_running[r]    = 1'b1;
          open_stack[nrtp_pkg::STACK_ADDR_BITS'(open_depth)] = r;
          open_depth++;
        end
      end
      nrtp_pkg::ACT_STOP_EXCL, nrtp_pkg::ACT_STOP_INCL: begin
        if (open_depth == 0 || stack_top() != r) begin
          st = nrtp_pkg::STAT_MISMATCH;
        end else if (!reg_running[r]) begin
          st = nrtp_pkg::STAT_IDLE_STOP;
        end else begin
          open_depth--;
          wall_del = wall_now - reg_wall_start[r];
          cpu_del  = cpu_now - reg_cpu_start[r];
          // take out what nested regions charged since the start
          if (act == nrtp_pkg::ACT_STOP_EXCL) begin
            wall_del  = wall_del - (nest_wall - reg_wall_snap[r]);
            cpu_del   = cpu_del - (nest_cpu - reg_cpu_snap[r]);
            nest_wall = nest_wall + wall_del;
            nest_cpu  = nest_cpu + cpu_del;
          end
          reg_wall_acc[r] = reg_wall_acc[r] + wall_del;
          reg_cpu_acc[r]  = reg_cpu_acc[r] + cpu_del;
          reg_running[r]  = 1'b0;
          if (reg_calls[r] != {nrtp_pkg::CALL_BITS{1'b1}})
            reg_calls[r] = reg_calls[r] + nrtp_pkg::CALL_BITS'(1);
        end
      end
      default: ;
    endcase
    t.status     = st;
    t.wall_total = reg_wall_acc[r];
    t.cpu_total  = reg_cpu_acc[r];
    t.calls      = reg_calls[r];
    return t;
  endfunction

  function automatic stim_row_t mk_row(nrtp_pkg::action_t a,
                                       logic [nrtp_pkg::REGION_IN_BITS-1:0] r,
                                       logic [nrtp_pkg::TIME_BITS-1:0] w,
                                       logic [nrtp_pkg::TIME_BITS-1:0] c,
                                       bit fixed, nrtp_pkg::status_t st,
                                       logic [nrtp_pkg::TIME_BITS-1:0] wt,
                                       logic [nrtp_pkg::TIME_BITS-1:0] ct,
                                       logic [nrtp_pkg::CALL_BITS-1:0] n);
    stim_row_t row;
    row.action = a;
    row.region = r;
    row.wall   = w;
    row.cpu    = c;
    row.fixed  = fixed;
    row.totals = '{status: st, wall_total: wt, cpu_total: ct, calls: n};
    return row;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
    error_count++;
  endtask

  // Present one event after a random gap and hold it until the transfer
  task automatic send_event(nrtp_pkg::action_t a, logic [nrtp_pkg::REGION_IN_BITS-1:0] r,
                            logic [nrtp_pkg::TIME_BITS-1:0] w,
                            logic [nrtp_pkg::TIME_BITS-1:0] c,
                            bit fixed, totals_t fixed_totals);
    while ($urandom_range(99) < tx_idle_pct) begin
      evt.valid <= 1'b0;
      @(negedge clk);
    end
    evt.valid        <= 1'b1;
    evt.action       <= a;
    evt.region       <= r;
    evt.wall_now     <= w;
    evt.cpu_now      <= c;
    row_fixed        = fixed;
    row_fixed_totals = fixed_totals;
    @(posedge clk);
    while (!evt.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Advance the stamp clocks, now and then jumping anywhere, and send
  task automatic send_random(nrtp_pkg::action_t a, logic [nrtp_pkg::REGION_IN_BITS-1:0] r);
    int unsigned step;
    step = $urandom_range(2000);
    if ($urandom_range(99) < 3) wall_clk = nrtp_pkg::TIME_BITS'({$urandom, $urandom});
    else wall_clk = wall_clk + nrtp_pkg::TIME_BITS'(step);
    if ($urandom_range(99) < 3) cpu_clk = nrtp_pkg::TIME_BITS'({$urandom, $urandom});
    else cpu_clk = cpu_clk + nrtp_pkg::TIME_BITS'($urandom_range(step));
    send_event(a, r, wall_clk, cpu_clk, 1'b0, '0);
  endtask

  task automatic stop_top();
    send_random(($urandom_range(99) < 70) ? nrtp_pkg::ACT_STOP_EXCL
                                           : nrtp_pkg::ACT_STOP_INCL,
                stack_top());
  endtask

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    res.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Check result transfers, then predict on event transfers
  always @(posedge clk) begin
    totals_t predicted;
    totals_t want;
    if (!rst) begin
      if (res.valid && res.ready) begin
        if (expected_totals.size() == 0) begin
          report_mismatch("unexpected result status", res.status, '0);
        end else begin
          want = expected_totals.pop_front();
          if (res.status !== want.status) report_mismatch("status", res.status, want.status);
          if (res.wall_total !== want.wall_total)
            report_mismatch("wall_total", res.wall_total, want.wall_total);
          if (res.cpu_total !== want.cpu_total)
            report_mismatch("cpu_total", res.cpu_total, want.cpu_total);
          if (res.calls !== want.calls) report_mismatch("calls", res.calls, want.calls);
        end
      end
      if (evt.valid && evt.ready) begin
        predicted = profile_event(nrtp_pkg::action_t'(evt.action), evt.region,
                                  evt.wall_now, evt.cpu_now);
        expected_totals.push_back(row_fixed ? row_fixed_totals : predicted);
      end
    end
  end

  initial begin
    int                                  n;
    nrtp_pkg::action_t                   a;
    logic [nrtp_pkg::REGION_IN_BITS-1:0] r;
    stim_row_t                           row;

    clk          = 1'b0;
    rst          = 1'b1;
    evt.valid    = 1'b0;
    evt.action   = nrtp_pkg::ACT_READ;
    evt.region   = '0;
    evt.wall_now = '0;
    evt.cpu_now  = '0;
    res.ready    = 1'b0;
    error_count  = 0;
    cycle_count  = 0;
    row_fixed    = 1'b0;
    row_fixed_totals = '0;
    tx_idle_pct  = 31;
    rx_idle_pct  = 56;
    wall_clk     = nrtp_pkg::TIME_BITS'({$urandom, $urandom});
    cpu_clk      = nrtp_pkg::TIME_BITS'({$urandom, $urandom});
    open_depth   = 0;
    nest_wall    = '0;
    nest_cpu     = '0;
    for (int i = 0; i < nrtp_pkg::REGIONS; i++) begin
      reg_wall_start[i] = '0;
      reg_wall_snap[i]  = '0;
      reg_wall_acc[i]   = '0;
      reg_cpu_start[i]  = '0;
      reg_cpu_snap[i]   = '0;
      reg_cpu_acc[i]    = '0;
      reg_calls[i]      = '0;
      reg_running[i]    = 1'b0;
    end
    for (int i = 0; i < nrtp_pkg::STACK_DEPTH; i++) open_stack[i] = '0;

    // Directed table: fixed rows are typed in, the rest go through the predictor
    // read after reset, both region extremes
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_READ, 6'd0, '0, '0, 1'b1,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_READ, 6'd63, TMAX, TMAX, 1'b1,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));
    // stops on an empty stack
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_STOP_EXCL, 6'd5, ts(1), ts(1), 1'b1,
                                   nrtp_pkg::STAT_MISMATCH, '0, '0, '0));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_STOP_INCL, 6'd63, ts(2), ts(2), 1'b1,
                                   nrtp_pkg::STAT_MISMATCH, '0, '0, '0));
    // restart while active, then a stop that is not the top of the stack
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_START, 6'd0, '0, TMAX, 1'b1,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_START, 6'd0, ts(3), ts(3), 1'b1,
                                   nrtp_pkg::STAT_RESTART, '0, '0, '0));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_START, 6'd63, TMAX, '0, 1'b1,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_STOP_EXCL, 6'd0, ts(4), ts(4), 1'b1,
                                   nrtp_pkg::STAT_MISMATCH, '0, '0, '0));
    // wrapping elapsed times, inclusive then exclusive
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_STOP_INCL, 6'd63, ts(5), ts(7), 1'b1,
                                   nrtp_pkg::STAT_OK, ts(6), ts(7),
                                   nrtp_pkg::CALL_BITS'(1)));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_STOP_EXCL, 6'd0, ts(100), ts(9), 1'b1,
                                   nrtp_pkg::STAT_OK, ts(100), ts(10),
                                   nrtp_pkg::CALL_BITS'(1)));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_STOP_EXCL, 6'd0, ts(101), ts(11), 1'b1,
                                   nrtp_pkg::STAT_MISMATCH, ts(100), ts(10),
                                   nrtp_pkg::CALL_BITS'(1)));
    // nested regions with an inclusive inner stop
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_START, 6'd1, ts(1000), ts(500), 1'b0,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_START, 6'd2, ts(1100), ts(550), 1'b0,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_START, 6'd3, ts(1150), ts(560), 1'b0,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_STOP_INCL, 6'd3, ts(1200), ts(600), 1'b0,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_STOP_EXCL, 6'd2, ts(1300), ts(650), 1'b0,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_STOP_EXCL, 6'd1, ts(2000), ts(900), 1'b0,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_READ, 6'd1, '0, '0, 1'b0,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_READ, 6'd2, '0, '0, 1'b0,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_READ, 6'd3, '0, '0, 1'b0,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_STOP_INCL, 6'd1, ts(2100), ts(950), 1'b0,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));
    // exclusive stop across the top of the stamp range
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_START, 6'd62, TMAX - ts(2), TMAX, 1'b0,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_STOP_EXCL, 6'd62, ts(3), ts(4), 1'b0,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));
    directed_rows.push_back(mk_row(nrtp_pkg::ACT_READ, 6'd62, '0, '0, 1'b0,
                                   nrtp_pkg::STAT_OK, '0, '0, '0));

    // Hold reset, release at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_event(row.action, row.region, row.wall, row.cpu, row.fixed, row.totals);
    end

    // Random nested sequences over three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 31;
          rx_idle_pct = 56;
        end
        1: begin
          tx_idle_pct = 56;
          rx_idle_pct = 31;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase

      repeat (130) begin
        n = $urandom_range(99);
        if (n < 5) begin
          // restart of an open region
          a = nrtp_pkg::ACT_START;
          if (open_depth > 0)
            r = open_stack[nrtp_pkg::STACK_ADDR_BITS'($urandom_range(open_depth - 1))];
          else r = nrtp_pkg::REGION_IN_BITS'($urandom);
        end else if (n < 11) begin
          // stop of an arbitrary region, mostly not the top
          a = $urandom_range(1) ? nrtp_pkg::ACT_STOP_EXCL : nrtp_pkg::ACT_STOP_INCL;
          r = nrtp_pkg::REGION_IN_BITS'($urandom);
        end else if (n < 18) begin
          a = nrtp_pkg::ACT_READ;
          r = nrtp_pkg::REGION_IN_BITS'($urandom);
        end else if (open_depth == 0 ||
                     (open_depth < nrtp_pkg::REGIONS && $urandom_range(99) < 52)) begin
          a = nrtp_pkg::ACT_START;
          do r = nrtp_pkg::REGION_IN_BITS'($urandom); while (reg_running[r]);
        end else begin
          a = ($urandom_range(99) < 70) ? nrtp_pkg::ACT_STOP_EXCL : nrtp_pkg::ACT_STOP_INCL;
          r = stack_top();
        end
        send_random(a, r);
      end

      // Open every region, try restarts on a full set, then unwind
      while (open_depth < nrtp_pkg::REGIONS) begin
        do r = nrtp_pkg::REGION_IN_BITS'($urandom); while (reg_running[r]);
        send_random(nrtp_pkg::ACT_START, r);
      end
      repeat (4) send_random(nrtp_pkg::ACT_START, nrtp_pkg::REGION_IN_BITS'($urandom));
      while (open_depth > 0) stop_top();
    end

    evt.valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
